// ----- sv/bzc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bzc_pkg
// Shared types and constants for the BEMF zero-crossing commutation block.
// ----------------------------------------------------------------------------
package bzc_pkg;

  // Datapath widths
  localparam int unsigned NUM_W  = 38;  // (phase + pi/6) * 1e6
  localparam int unsigned DEN_W  = 43;  // q * 2pi, also 6 * dt
  localparam int unsigned Q_W    = 24;  // q = tick_rate / (6 * dt)
  localparam int unsigned QDEPTH = 2;   // front-to-back queue depth

  // Arithmetic constants
  localparam logic [31:0] STEP_ANGLE   = 32'd357913941;  // 1/6 turn, Q31 full turn
  localparam logic [17:0] PI_SIXTH_Q16 = 18'd34315;
  localparam logic [18:0] TWO_PI_Q16   = 19'd411775;
  localparam logic [19:0] US_PER_S     = 20'd1000000;
  localparam logic [31:0] DELAY_SAT    = 32'hFFFF_FFFF;

  // Reset values of the configuration registers
  localparam logic [15:0] THR_HIGH_RST  = 16'sd100;
  localparam logic [15:0] THR_LOW_RST   = -16'sd100;
  localparam logic [17:0] PHASE_RST     = 18'd0;
  localparam logic [26:0] TICK_RATE_RST = 27'd1000000;

  // Direction codes (2-bit signed)
  localparam logic [1:0] DIR_HOLD    = 2'b00;
  localparam logic [1:0] DIR_FWD     = 2'b01;
  localparam logic [1:0] DIR_REV2    = 2'b10;
  localparam logic [1:0] DIR_REV     = 2'b11;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_THR_HIGH  = 2'd0,
    CFG_THR_LOW   = 2'd1,
    CFG_PHASE     = 2'd2,
    CFG_TICK_RATE = 2'd3
  } cfg_idx_t;

  // Classified word handed from front to back
  typedef struct packed {
    logic        crossing;
    logic        rising;
    logic [31:0] angle;
    logic [31:0] dt;
  } zc_word_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV_Q,
    BK_MUL,
    BK_DIV_START,
    BK_DIV_D,
    BK_DONE
  } bk_state_t;

endpackage
`default_nettype wire

// ----- sv/bemf_zero_cross_commutation.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bemf_zero_cross_commutation
// Sensorless BLDC back-EMF zero-crossing detector and commutation delay.
// ----------------------------------------------------------------------------
// Each input word is one back-EMF sample with its timestamp and rotation
// direction and yields exactly one result word. A hysteresis comparator
// flags rising (above the high threshold) and falling (below the low
// threshold) crossings; each crossing steps the electrical angle by
// direction * 1/6 turn, measures the tick interval dt since the previous
// crossing, and computes q = tick_rate / (6 * dt) and the commutation delay
// (phase_offset + pi/6) * 1e6 / (q * 2pi) in microseconds (Q16 radians).
// Zero dt or zero q returns delay 0xFFFFFFFF with delay_invalid set.
// func = 1 clears the comparator and angle (the crossing timestamp is kept).
// Timing: the front classifies a sample in its accept cycle and queues it
// (two entries). The back runs one shared restoring divider, one quotient
// bit per cycle over 38 bits, twice for a crossing with nonzero q, once
// for a crossing whose q comes out zero, and not at all for a word without
// a crossing (or with zero interval); it takes no new word until the last
// result is loaded into the output register. Configuration writes are always ready and
// must be made while the block is idle.
// ----------------------------------------------------------------------------
module bemf_zero_cross_commutation (
  input  wire logic               clk,
  input  wire logic               rst,
  // configuration
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic        [1:0]  cfg_index,
  input  wire logic        [26:0] cfg_data,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               func,
  input  wire logic signed [15:0] bemf_sample,
  input  wire logic        [31:0] timestamp,
  input  wire logic signed [1:0]  direction,
  // output channel
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    crossing,
  output logic                    rising_edge,
  output logic signed      [31:0] angle,
  output logic             [31:0] interval_ticks,
  output logic             [31:0] comm_delay,
  output logic                    delay_invalid
);

  // configuration registers
  logic signed [15:0] thr_high;
  logic signed [15:0] thr_low;
  logic        [17:0] phase_offset;
  logic        [26:0] tick_rate;

  bzc_pkg::zc_word_t front_word;
  bzc_pkg::zc_word_t fifo_word;
  logic              push;
  logic              pop;
  logic              fifo_empty;
  logic              fifo_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = fifo_full;
  assign push      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr_high     <= bzc_pkg::THR_HIGH_RST;
      thr_low      <= bzc_pkg::THR_LOW_RST;
      phase_offset <= bzc_pkg::PHASE_RST;
      tick_rate    <= bzc_pkg::TICK_RATE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bzc_pkg::cfg_idx_t'(cfg_index))
        bzc_pkg::CFG_THR_HIGH:  thr_high     <= cfg_data[15:0];
        bzc_pkg::CFG_THR_LOW:   thr_low      <= cfg_data[15:0];
        bzc_pkg::CFG_PHASE:     phase_offset <= cfg_data[17:0];
        bzc_pkg::CFG_TICK_RATE: tick_rate    <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: comparator, angle, interval
  bzc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .func        (func),
    .bemf_sample (bemf_sample),
    .timestamp   (timestamp),
    .direction   (direction),
    .thr_high    (thr_high),
    .thr_low     (thr_low),
    .word        (front_word)
  );

  // queue decouples classification from the divider
  bzc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .word_in  (front_word),
    .pop      (pop),
    .word_out (fifo_word),
    .empty    (fifo_empty),
    .full     (fifo_full)
  );

  // back: speed, delay, output register
  bzc_back u_back (
    .clk            (clk),
    .rst            (rst),
    .fifo_empty     (fifo_empty),
    .fifo_word      (fifo_word),
    .fifo_pop       (pop),
    .phase_offset   (phase_offset),
    .tick_rate      (tick_rate),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .crossing       (crossing),
    .rising_edge    (rising_edge),
    .angle          (angle),
    .interval_ticks (interval_ticks),
    .comm_delay     (comm_delay),
    .delay_invalid  (delay_invalid)
  );

endmodule
`default_nettype wire

// ----- sv/bzc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bzc_front
// Hysteresis comparator, angle accumulator and crossing interval.
// ----------------------------------------------------------------------------
module bzc_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  input  wire logic               func,
  input  wire logic signed [15:0] bemf_sample,
  input  wire logic        [31:0] timestamp,
  input  wire logic signed [1:0]  direction,
  input  wire logic signed [15:0] thr_high,
  input  wire logic signed [15:0] thr_low,
  output bzc_pkg::zc_word_t       word
);

  logic        comp_high;
  logic [31:0] angle_acc;
  logic [31:0] last_time;

  logic        rising;
  logic        falling;
  logic [31:0] angle_step;
  logic [31:0] angle_next;

  always_comb begin
    rising  = (bemf_sample > thr_high) && !comp_high;
    falling = (bemf_sample < thr_low) && comp_high;

    unique case (direction)
      bzc_pkg::DIR_FWD:  angle_step = bzc_pkg::STEP_ANGLE;
      bzc_pkg::DIR_REV:  angle_step = -bzc_pkg::STEP_ANGLE;
      bzc_pkg::DIR_REV2: angle_step = -(bzc_pkg::STEP_ANGLE << 1);
      default:           angle_step = '0;
    endcase

    angle_next = (rising || falling) ? angle_acc + angle_step : angle_acc;

    word = '0;
    if (!func) begin
      word.crossing = rising || falling;
      word.rising   = rising;
      word.angle    = angle_next;
      word.dt       = (rising || falling) ? timestamp - last_time : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      comp_high <= 1'b0;
      angle_acc <= '0;
      last_time <= '0;
    end else if (push) begin
      if (func) begin
        comp_high <= 1'b0;
        angle_acc <= '0;
      end else if (rising || falling) begin
        comp_high <= rising;
        angle_acc <= angle_next;
        last_time <= timestamp;
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/bzc_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bzc_fifo
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module bzc_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire bzc_pkg::zc_word_t word_in,
  input  wire logic              pop,
  output bzc_pkg::zc_word_t      word_out,
  output logic                   empty,
  output logic                   full
);

  localparam int unsigned AW = $clog2(bzc_pkg::QDEPTH);
  localparam int unsigned CW = $clog2(bzc_pkg::QDEPTH + 1);

  bzc_pkg::zc_word_t slots [bzc_pkg::QDEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign empty    = (count == '0);
  assign full     = (count == CW'(bzc_pkg::QDEPTH));
  assign word_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(bzc_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(bzc_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= word_in;
    end
  end

endmodule
`default_nettype wire

// ----- sv/bzc_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bzc_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bzc_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [bzc_pkg::NUM_W-1:0] dividend,
  input  wire logic [bzc_pkg::DEN_W-1:0] divisor,
  output logic                           done,
  output logic      [bzc_pkg::NUM_W-1:0] quotient
);

  localparam int unsigned NW = bzc_pkg::NUM_W;
  localparam int unsigned DW = bzc_pkg::DEN_W;
  localparam int unsigned CW = $clog2(NW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [DW-1:0] rem;
  logic [NW-1:0] dvd;
  logic [DW-1:0] dsr;

  logic [DW:0]   shifted;
  logic [DW+1:0] diff;
  logic          fits;

  // partial remainder stays below the divisor, so DW bits hold it
  always_comb begin
    shifted = {rem, dvd[NW-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr};
    fits    = !diff[DW+1];
  end

  assign quotient = dvd;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[DW-1:0] : shifted[DW-1:0];
      dvd <= {dvd[NW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

// ----- sv/bzc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bzc_back
// Speed and commutation delay sequencer with output register.
// ----------------------------------------------------------------------------
module bzc_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fifo_empty,
  input  wire bzc_pkg::zc_word_t  fifo_word,
  output logic                    fifo_pop,
  input  wire logic        [17:0] phase_offset,
  input  wire logic        [26:0] tick_rate,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    crossing,
  output logic                    rising_edge,
  output logic signed      [31:0] angle,
  output logic             [31:0] interval_ticks,
  output logic             [31:0] comm_delay,
  output logic                    delay_invalid
);

  localparam int unsigned NW = bzc_pkg::NUM_W;
  localparam int unsigned DW = bzc_pkg::DEN_W;
  localparam int unsigned QW = bzc_pkg::Q_W;

  bzc_pkg::bk_state_t state, state_next;

  bzc_pkg::zc_word_t ent;
  logic [QW-1:0] q;
  logic [NW-1:0] num;
  logic [DW-1:0] den;
  logic [31:0]   delay;
  logic          invalid;

  logic          div_start;
  logic [NW-1:0] div_dividend;
  logic [DW-1:0] div_divisor;
  logic          div_done;
  logic [NW-1:0] div_quot;
  logic          load_out;

  bzc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    state_next   = state;
    fifo_pop     = 1'b0;
    div_start    = 1'b0;
    div_dividend = num;
    div_divisor  = den;
    load_out     = 1'b0;

    unique case (state)
      bzc_pkg::BK_IDLE: begin
        if (!fifo_empty) begin
          fifo_pop = 1'b1;
          if (fifo_word.crossing && (fifo_word.dt != '0)) begin
            // q = floor(tick_rate / (6 * dt))
            div_start    = 1'b1;
            div_dividend = NW'(tick_rate);
            div_divisor  = (DW'(fifo_word.dt) << 2) + (DW'(fifo_word.dt) << 1);
            state_next   = bzc_pkg::BK_DIV_Q;
          end else begin
            state_next = bzc_pkg::BK_DONE;
          end
        end
      end
      bzc_pkg::BK_DIV_Q: begin
        if (div_done) begin
          state_next = (div_quot == '0) ? bzc_pkg::BK_DONE : bzc_pkg::BK_MUL;
        end
      end
      bzc_pkg::BK_MUL: begin
        state_next = bzc_pkg::BK_DIV_START;
      end
      bzc_pkg::BK_DIV_START: begin
        div_start  = 1'b1;
        state_next = bzc_pkg::BK_DIV_D;
      end
      bzc_pkg::BK_DIV_D: begin
        if (div_done) begin
          state_next = bzc_pkg::BK_DONE;
        end
      end
      bzc_pkg::BK_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = bzc_pkg::BK_IDLE;
        end
      end
      default: state_next = bzc_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bzc_pkg::BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      ent     <= fifo_word;
      // zero interval saturates; overwritten once a real delay is known
      delay   <= fifo_word.crossing ? bzc_pkg::DELAY_SAT : '0;
      invalid <= fifo_word.crossing;
    end
    if (state == bzc_pkg::BK_DIV_Q && div_done) begin
      q <= div_quot[QW-1:0];
    end
    if (state == bzc_pkg::BK_MUL) begin
      num <= NW'(phase_offset + bzc_pkg::PI_SIXTH_Q16) * NW'(bzc_pkg::US_PER_S);
      den <= DW'(q) * DW'(bzc_pkg::TWO_PI_Q16);
    end
    if (state == bzc_pkg::BK_DIV_D && div_done) begin
      delay   <= div_quot[31:0];
      invalid <= 1'b0;
    end
    if (load_out) begin
      crossing       <= ent.crossing;
      rising_edge    <= ent.rising;
      angle          <= ent.angle;
      interval_ticks <= ent.dt;
      comm_delay     <= delay;
      delay_invalid  <= invalid;
    end
  end

endmodule
`default_nettype wire
